// ===== src/skte_pkg.sv =====
// ----------------------------------------------------------------------------
// skte_pkg
// shared types and constants of the sorted key table engine
// ----------------------------------------------------------------------------
package skte_pkg;
    localparam int TableDepth = 1024;
    localparam int AddrW      = $clog2(TableDepth);
    localparam int CountW     = $clog2(TableDepth + 1);
    localparam int KeyW       = 8;
    localparam int TagW       = 16;
    localparam int IdxW       = 10;
    localparam int EntryW     = KeyW + TagW;

    localparam logic [1:0] KindInsert = 2'd0;
    localparam logic [1:0] KindFind   = 2'd1;
    localparam logic [1:0] KindDelete = 2'd2;
    localparam logic [1:0] KindUnused = 2'd3;

    localparam logic [1:0] StatOk       = 2'd0;
    localparam logic [1:0] StatFull     = 2'd1;
    localparam logic [1:0] StatNotFound = 2'd2;
    localparam logic [1:0] StatBadRange = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_UP_RD,
        ST_UP_CHK,
        ST_DN_RD,
        ST_DN_CHK,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_GAP_RD0,
        ST_GAP_RD1,
        ST_GAP_DONE,
        ST_OUT
    } t_state;
endpackage

// ===== src/skte_ram.sv =====
// ----------------------------------------------------------------------------
// skte_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module skte_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/sorted_key_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_engine_top
// sorted (key, tag) table with insert, range find and range delete
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | i_valid/o_ready, i_kind i_key_value i_tag_value
//         |           | i_first_index i_last_index
// out     | output    | o_valid/i_ready, o_status o_low_index o_high_index
//         |           | o_entry_count o_key_gap
// one transaction at a time through a single-port table ram
// binary search takes a ram read state and a compare state per probe
// insert shift and delete compaction take a read and a write state per moved entry
// find range growth takes a read and a check state per equal key; key gap reads both ends
// reset clears the count; ram contents need no clearing
// the result register holds while o_valid waits for i_ready
// ----------------------------------------------------------------------------
module sorted_key_table_engine_top
    import skte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [KeyW-1:0]   i_key_value,
    input  logic [TagW-1:0]   i_tag_value,
    input  logic [IdxW-1:0]   i_first_index,
    input  logic [IdxW-1:0]   i_last_index,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [IdxW-1:0]   o_low_index,
    output logic [IdxW-1:0]   o_high_index,
    output logic [CountW-1:0] o_entry_count,
    output logic [KeyW-1:0]   o_key_gap
);
    t_state r_state, n_state;
    logic [CountW-1:0] r_count, n_count;
    logic [1:0]        r_kind;
    logic [KeyW-1:0]   r_key, r_k0, n_k0;
    logic [TagW-1:0]   r_tag;
    logic [AddrW-1:0]  r_first, r_last;
    logic [CountW:0]   r_lo, r_hi, n_lo, n_hi;
    logic [CountW-1:0] r_mid, n_mid, r_ptr, n_ptr, r_a, n_a, r_b, n_b;
    logic [1:0]        r_stat, n_stat;
    logic [CountW-1:0] r_olo, n_olo, r_ohi, n_ohi;
    logic [KeyW-1:0]   r_gap, n_gap;

    logic              we;
    logic [AddrW-1:0]  addr;
    logic [EntryW-1:0] wdata, rdata;
    logic [KeyW-1:0]   rkey;
    logic [CountW-1:0] span;
    logic [CountW:0]   mid_w;

    assign rkey  = rdata[EntryW-1:TagW];
    assign span  = CountW'(r_last) - CountW'(r_first) + 1'b1;
    assign mid_w = (r_lo + r_hi) >> 1;

    skte_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        if (r_state == ST_IDLE && i_valid) begin
            r_kind  <= i_kind;
            r_key   <= i_key_value;
            r_tag   <= i_tag_value;
            r_first <= AddrW'(i_first_index);
            r_last  <= AddrW'(i_last_index);
        end
        r_lo <= n_lo; r_hi <= n_hi; r_mid <= n_mid; r_ptr <= n_ptr;
        r_a <= n_a; r_b <= n_b; r_stat <= n_stat; r_olo <= n_olo;
        r_ohi <= n_ohi; r_gap <= n_gap; r_k0 <= n_k0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_kind)
                        KindInsert: n_state = (r_count >= CountW'(TableDepth)) ? ST_GAP_RD0 :
                                              (r_count == '0) ? ST_INS_PUT : ST_SRCH_RD;
                        KindFind:   n_state = (r_count == '0) ? ST_OUT : ST_SRCH_RD;
                        KindDelete: n_state = (i_first_index > i_last_index ||
                                               CountW'(i_last_index) >= r_count) ? ST_GAP_RD0 :
                                              ST_DEL_RD;
                        default:    n_state = ST_GAP_RD0;
                    endcase
                end
            end
            ST_SRCH_RD: n_state = ST_SRCH_CHK;
            ST_SRCH_CHK: begin
                if (rkey == r_key) begin
                    n_state = (r_kind == KindInsert) ? ST_INS_RD : ST_UP_RD;
                end else if ((rkey < r_key && CountW'(r_mid) + 1'b1 > CountW'(r_hi))
                             || (rkey > r_key && r_mid == CountW'(r_lo))) begin
                    n_state = (r_kind == KindInsert) ? ST_INS_RD : ST_GAP_RD0;
                end else begin
                    n_state = ST_SRCH_RD;
                end
            end
            ST_INS_RD:  n_state = (r_ptr == r_mid) ? ST_INS_PUT : ST_INS_WR;
            ST_INS_WR:  n_state = ST_INS_RD;
            ST_INS_PUT: n_state = ST_GAP_RD0;
            ST_UP_RD:   n_state = ST_UP_CHK;
            ST_UP_CHK:  n_state = (rkey == r_key && r_a + 1'b1 < r_count) ? ST_UP_RD :
                                  ST_DN_RD;
            ST_DN_RD:   n_state = ST_DN_CHK;
            ST_DN_CHK:  n_state = (r_b != '0 && rkey == r_key) ? ST_DN_RD : ST_GAP_RD0;
            ST_DEL_RD:  n_state = (r_ptr >= r_count) ? ST_GAP_RD0 : ST_DEL_WR;
            ST_DEL_WR:  n_state = ST_DEL_RD;
            ST_GAP_RD0: n_state = (r_count == '0) ? ST_GAP_DONE : ST_GAP_RD1;
            ST_GAP_RD1: n_state = ST_GAP_DONE;
            ST_GAP_DONE: n_state = ST_OUT;
            ST_OUT:     n_state = i_ready ? ST_IDLE : ST_OUT;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count = r_count; n_lo = r_lo; n_hi = r_hi; n_mid = r_mid; n_ptr = r_ptr;
        n_a = r_a; n_b = r_b; n_stat = r_stat; n_olo = r_olo; n_ohi = r_ohi;
        n_gap = r_gap; n_k0 = r_k0;
        we = 1'b0; addr = '0; wdata = '0;
        unique case (r_state)
            ST_IDLE: begin
                n_stat = StatOk; n_olo = '0; n_ohi = '0; n_gap = '0;
                n_lo = '0; n_hi = {1'b0, r_count} - 1'b1; n_mid = '0; n_ptr = r_count;
                if (i_valid) begin
                    if (i_kind == KindInsert && r_count >= CountW'(TableDepth)) begin
                        n_stat = StatFull;
                    end else if (i_kind == KindFind && r_count == '0) begin
                        n_stat = StatNotFound;
                    end else if (i_kind == KindDelete) begin
                        if (i_first_index > i_last_index || CountW'(i_last_index) >= r_count)
                            n_stat = StatBadRange;
                        n_ptr = CountW'(i_last_index) + 1'b1;
                    end
                end
            end
            ST_SRCH_RD: begin
                n_mid = CountW'(mid_w);
                addr = AddrW'(mid_w);
            end
            ST_SRCH_CHK: begin
                if (rkey == r_key) begin
                    n_a = r_mid; n_b = r_mid;
                end else if (rkey < r_key) begin
                    n_lo = {1'b0, r_mid} + 1'b1;
                    if (CountW'(r_mid) + 1'b1 > CountW'(r_hi)) n_mid = r_mid + 1'b1;
                end else begin
                    n_hi = {1'b0, r_mid} - 1'b1;
                end
                if (r_kind == KindFind && rkey != r_key &&
                    ((rkey < r_key && CountW'(r_mid) + 1'b1 > CountW'(r_hi)) ||
                     (rkey > r_key && r_mid == CountW'(r_lo))))
                    n_stat = StatNotFound;
            end
            ST_INS_RD: begin
                addr = AddrW'(r_ptr - 1'b1);
            end
            ST_INS_WR: begin
                we = 1'b1; addr = AddrW'(r_ptr); wdata = rdata;
                n_ptr = r_ptr - 1'b1;
            end
            ST_INS_PUT: begin
                we = 1'b1; addr = AddrW'(r_mid); wdata = {r_key, r_tag};
                n_count = r_count + 1'b1;
                n_olo = r_mid; n_ohi = r_mid;
            end
            ST_UP_RD: begin
                addr = AddrW'(r_a + 1'b1);
            end
            ST_UP_CHK: begin
                if (r_a + 1'b1 < r_count && rkey == r_key) n_a = r_a + 1'b1;
                if (r_b != '0) addr = AddrW'(r_b - 1'b1);
            end
            ST_DN_RD: begin
                addr = AddrW'(r_b - 1'b1);
            end
            ST_DN_CHK: begin
                if (r_b != '0 && rkey == r_key) begin
                    n_b = r_b - 1'b1;
                end
                n_olo = n_b; n_ohi = r_a;
            end
            ST_DEL_RD: begin
                addr = AddrW'(r_ptr);
                if (r_ptr >= r_count) begin
                    n_count = r_count - span;
                    n_olo = CountW'(r_first); n_ohi = CountW'(r_first);
                end
            end
            ST_DEL_WR: begin
                we = 1'b1; addr = AddrW'(r_ptr - span); wdata = rdata;
                n_ptr = r_ptr + 1'b1;
            end
            ST_GAP_RD0: begin
                addr = '0;
            end
            ST_GAP_RD1: begin
                addr = AddrW'(r_count - 1'b1);
                n_k0 = rkey;
            end
            ST_GAP_DONE: begin
                if (r_count != '0) n_gap = rkey - r_k0;
            end
            default: ;
        endcase
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_status      = r_stat;
    assign o_low_index   = IdxW'(r_olo);
    assign o_high_index  = IdxW'(r_ohi);
    assign o_entry_count = r_count;
    assign o_key_gap     = r_gap;
endmodule

// ===== dv/sorted_key_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_checker
// watches both channels of the sorted key table engine, keeps its own sorted
// table, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module sorted_key_table_checker
    import skte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [KeyW-1:0]   i_key_value,
    input  logic [TagW-1:0]   i_tag_value,
    input  logic [IdxW-1:0]   i_first_index,
    input  logic [IdxW-1:0]   i_last_index,
    input  logic              o_valid,
    input  logic              i_ready,
    input  logic [1:0]        o_status,
    input  logic [IdxW-1:0]   o_low_index,
    input  logic [IdxW-1:0]   o_high_index,
    input  logic [CountW-1:0] o_entry_count,
    input  logic [KeyW-1:0]   o_key_gap,
    output int                o_fail_count,
    output int                o_pending
);
    typedef struct packed {
        logic [1:0]        status;
        logic [IdxW-1:0]   low;
        logic [IdxW-1:0]   high;
        logic [CountW-1:0] count;
        logic [KeyW-1:0]   gap;
    } t_table_result;

    logic [KeyW-1:0] keys [TableDepth];
    logic [TagW-1:0] tags [TableDepth];
    int              fill;
    t_table_result   expected_q [$];

    function automatic bit key_search(input logic [KeyW-1:0] key, output int pos);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = fill - 1;
        mid = 0;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (keys[mid] == key) begin
                pos = mid;
                return 1'b1;
            end
            if (key > keys[mid]) lo = mid + 1;
            else hi = mid - 1;
        end
        pos = mid;
        return 1'b0;
    endfunction

    function automatic t_table_result table_operation(
        input logic [1:0] kind, input logic [KeyW-1:0] key, input logic [TagW-1:0] tag,
        input int first, input int last);
        t_table_result res;
        int pos;
        int a;
        int b;
        int span;
        res = '0;
        case (kind)
            KindInsert: begin
                if (fill >= TableDepth) begin
                    res.status = StatFull;
                end else begin
                    if (!key_search(key, pos))
                        if (pos < fill && keys[pos] < key) pos++;
                    for (int i = fill; i > pos; i--) begin
                        keys[i] = keys[i-1];
                        tags[i] = tags[i-1];
                    end
                    keys[pos] = key;
                    tags[pos] = tag;
                    fill++;
                    res.low  = IdxW'(pos);
                    res.high = IdxW'(pos);
                end
            end
            KindFind: begin
                if (!key_search(key, pos)) begin
                    res.status = StatNotFound;
                end else begin
                    a = pos;
                    b = pos;
                    while (a + 1 < fill && keys[a+1] == key) a++;
                    while (b > 0 && keys[b-1] == key) b--;
                    res.low  = IdxW'(b);
                    res.high = IdxW'(a);
                end
            end
            KindDelete: begin
                if (first > last || last >= fill) begin
                    res.status = StatBadRange;
                end else begin
                    span = last - first + 1;
                    for (int i = last + 1; i < fill; i++) begin
                        keys[i-span] = keys[i];
                        tags[i-span] = tags[i];
                    end
                    fill -= span;
                    res.low  = IdxW'(first);
                    res.high = IdxW'(first);
                end
            end
            default: ;
        endcase
        res.count = CountW'(fill);
        if (fill > 0) res.gap = keys[fill-1] - keys[0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_table_result exp_res;
        if (!i_rst_n) begin
            fill = 0;
            expected_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid && o_ready)
                expected_q.push_back(table_operation(i_kind, i_key_value, i_tag_value,
                                                     i_first_index, i_last_index));
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = expected_q.pop_front();
                    if ({o_status, o_low_index, o_high_index, o_entry_count, o_key_gap}
                        != exp_res) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_status != exp_res.status)
                            $error("status: expected %0d actual %0d", exp_res.status, o_status);
                        if (o_low_index != exp_res.low)
                            $error("low_index: expected %0d actual %0d", exp_res.low,
                                   o_low_index);
                        if (o_high_index != exp_res.high)
                            $error("high_index: expected %0d actual %0d", exp_res.high,
                                   o_high_index);
                        if (o_entry_count != exp_res.count)
                            $error("entry_count: expected %0d actual %0d", exp_res.count,
                                   o_entry_count);
                        if (o_key_gap != exp_res.gap)
                            $error("key_gap: expected %0d actual %0d", exp_res.gap,
                                   o_key_gap);
                    end
                end
            end
            o_pending <= expected_q.size();
        end
    end
endmodule

// ===== dv/tb_sorted_key_table_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_table_engine_top
// drives insert, find, delete and unused-kind transactions into the sorted key table
// engine: directed corner cases, a fill to full depth, then random traffic
// under several idle and stall mixes; the checker gives the verdict count
// ----------------------------------------------------------------------------
module tb_sorted_key_table_engine_top;
    import skte_pkg::*;

    localparam int CycleLimit = 6000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_kind;
    logic [KeyW-1:0]   i_key_value;
    logic [TagW-1:0]   i_tag_value;
    logic [IdxW-1:0]   i_first_index;
    logic [IdxW-1:0]   i_last_index;
    logic              o_valid;
    logic              i_ready;
    logic [1:0]        o_status;
    logic [IdxW-1:0]   o_low_index;
    logic [IdxW-1:0]   o_high_index;
    logic [CountW-1:0] o_entry_count;
    logic [KeyW-1:0]   o_key_gap;
    int                fail_count;
    int                pending;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                cycles;
    int                table_fill;

    sorted_key_table_engine_top dut (.*);

    sorted_key_table_checker checker_i (
        .*,
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send(input logic [1:0] kind, input int key, input int tag,
                        input int first, input int last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_key_value   <= KeyW'(key);
        i_tag_value   <= TagW'(tag);
        i_first_index <= IdxW'(first);
        i_last_index  <= IdxW'(last);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        case (kind)
            KindInsert: if (table_fill < TableDepth) table_fill++;
            KindDelete: if (first <= last && last < table_fill)
                table_fill -= last - first + 1;
            default: ;
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int n);
        int sel;
        int first;
        int key;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            key = ($urandom_range(1)) ? $urandom_range(255) : $urandom_range(8) * 30;
            if (sel < 45 && table_fill < 120 || table_fill == 0 && sel < 80) begin
                send(KindInsert, key, $urandom, 0, 0);
            end else if (sel < 75) begin
                send(KindFind, key, $urandom, $urandom, $urandom);
            end else if (sel < 94 && table_fill > 0) begin
                first = $urandom_range(table_fill - 1);
                send(KindDelete, key, $urandom, first,
                     first + $urandom_range((table_fill - 1 - first) < 3 ?
                                            (table_fill - 1 - first) : 3));
            end else if (sel < 97) begin
                send(KindDelete, key, $urandom, $urandom, $urandom);
            end else begin
                send(KindUnused, key, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        cycles         = 0;
        table_fill     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_kind         = KindInsert;
        i_key_value    = '0;
        i_tag_value    = '0;
        i_first_index  = '0;
        i_last_index   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        send(KindFind, 5, 0, 0, 0);
        send(KindDelete, 0, 0, 0, 0);
        send(KindUnused, 255, 16'hffff, 1023, 1023);
        send(KindInsert, 0, 0, 0, 0);
        send(KindInsert, 255, 16'hffff, 0, 0);
        send(KindInsert, 100, 16'h1234, 0, 0);
        send(KindInsert, 100, 16'h4321, 0, 0);
        send(KindInsert, 100, 16'h5555, 0, 0);
        send(KindInsert, 50, 16'haaaa, 0, 0);
        send(KindFind, 100, 0, 0, 0);
        send(KindFind, 0, 0, 0, 0);
        send(KindFind, 255, 0, 0, 0);
        send(KindFind, 101, 0, 0, 0);
        send(KindDelete, 0, 0, 3, 2);
        send(KindDelete, 0, 0, 0, 6);
        send(KindDelete, 0, 0, 1023, 1023);
        send(KindDelete, 0, 0, 2, 3);
        send(KindDelete, 0, 0, 0, 0);
        send(KindFind, 100, 0, 0, 0);
        send(KindDelete, 0, 0, 0, table_fill - 1);
        drain();

        // fill to full depth with non-decreasing keys, then overflow and clear
        for (int k = 0; k < TableDepth; k++)
            send(KindInsert, k >> 2, $urandom, 0, 0);
        send(KindInsert, 7, 16'hffff, 0, 0);
        send(KindFind, 255, 0, 0, 0);
        send(KindDelete, 0, 0, 1023, 1023);
        send(KindDelete, 0, 0, 0, 1022);
        send(KindDelete, 0, 0, 0, 0);

        random_traffic(150);
        drain();
        send_idle_pct = 85;
        random_traffic(140);
        send_idle_pct  = 0;
        recv_stall_pct = 85;
        random_traffic(140);
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        random_traffic(140);
        drain();
        recv_stall_pct = 0;
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
